/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the glob pattern set matcher.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge while reset is released.
`define GPM_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gpm assertion failed");
// Checked on every rising edge, reset included.
`define GPM_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gpm assertion failed");
`else
`define GPM_ASSERT_RST(lbl, clk, rst_n, prop)
`define GPM_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

/* design/gpm_pkg.sv */
// ---------------------------------------------------------------------------
// gpm_pkg
// Constants, codes and types shared by the glob pattern set matcher modules.
// ---------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

    // Table geometry.
    localparam int NUM_PATTERNS = 16;
    localparam int PATTERN_LEN  = 63;
    localparam int CHAR_W       = 8;
    localparam int SLOT_W       = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int POS_W        = 6;
    localparam int ROW_W        = PATTERN_LEN * CHAR_W;
    localparam int VEC_W        = PATTERN_LEN + 1;

    // Fixed field widths of the ports.
    localparam int USE_W        = 5;
    localparam int OUT_SLOT_W   = 4;
    localparam int ACT_W        = 2;

    // Command queue depth between front and back.
    localparam int QUEUE_DEPTH  = 2;

    // Special characters.
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_END   = 8'h00;

    // Input action codes.
    localparam logic [ACT_W-1:0] ACT_PAT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NAME_CHAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NAME_END  = 2'd2;

    // Queued operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // One classified command as it travels through the queue.
    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] char_code;
    } cmd_t;

endpackage

`default_nettype wire

/* design/gpm_front.sv */
// ---------------------------------------------------------------------------
// gpm_front
// Accepts input transfers, drops those without effect and classifies the rest.
// ---------------------------------------------------------------------------
`default_nettype none

module gpm_front import gpm_pkg::*; (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ACT_W-1:0]  s_action,
    input  wire logic [3:0]        s_slot,
    input  wire logic [POS_W-1:0]  s_position,
    input  wire logic [CHAR_W-1:0] s_char_code,
    input  wire logic              q_full,
    output logic                   push,
    output cmd_t                   push_cmd
);

    logic keep;

    // A transfer is taken whenever the queue has room.
    assign s_ready = !q_full;

    // Decide whether the item does anything and which operation it becomes.
    always_comb begin
        keep        = 1'b0;
        push_cmd.op = OP_WRITE;
        case (s_action)
            ACT_PAT_WRITE: begin
                keep        = (int'(s_position) < PATTERN_LEN) &&
                              (int'(s_slot) < NUM_PATTERNS);
                push_cmd.op = OP_WRITE;
            end
            ACT_NAME_CHAR: begin
                keep        = (s_char_code != CH_END);
                push_cmd.op = OP_CHAR;
            end
            ACT_NAME_END: begin
                keep        = 1'b1;
                push_cmd.op = OP_END;
            end
            default: begin
                keep        = 1'b0;
                push_cmd.op = OP_WRITE;
            end
        endcase
        push_cmd.slot      = SLOT_W'(s_slot);
        push_cmd.pos       = s_position;
        push_cmd.char_code = s_char_code;
    end

    assign push = s_valid && s_ready && keep;

endmodule

`default_nettype wire

/* design/gpm_queue.sv */
// ---------------------------------------------------------------------------
// gpm_queue
// Short command FIFO that decouples the front from the matching engine.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gpm_queue import gpm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `GPM_ASSERT_RST(a_no_overflow, aclk, aresetn, push |-> (!full || pop))
    `GPM_ASSERT_RST(a_no_underflow, aclk, aresetn, pop |-> !empty)
    `GPM_ASSERT_RST(a_count_range, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

/* design/gpm_back.sv */
// ---------------------------------------------------------------------------
// gpm_back
// Matching engine: pattern memory, per-slot matcher sweep and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gpm_back import gpm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [USE_W-1:0]      patterns_in_use,
    input  wire logic                  q_empty,
    input  wire cmd_t                  head_cmd,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_ignored,
    output logic [OUT_SLOT_W-1:0]      m_first_match_slot
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    // Sequencer state.
    logic [1:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              prog_reg, prog_next;
    logic              out_load;
    logic              sweep_start;
    logic              pipe_busy;

    // Pattern memory, one row per slot.
    logic [ROW_W-1:0]  pat_mem [NUM_PATTERNS];

    // Stage 1: registered memory row.
    logic              p1_valid_reg;
    logic [SLOT_W-1:0] p1_slot_reg;
    logic [ROW_W-1:0]  row_reg;

    // Stage 2: position masks of the pattern.
    logic                   p2_valid_reg;
    logic [SLOT_W-1:0]      p2_slot_reg;
    logic [PATTERN_LEN-1:0] star2_reg, match2_reg;
    logic [VEC_W-1:0]       end2_reg;
    logic [PATTERN_LEN-1:0] zf, below, lowest, is_star, is_match;
    logic                   seen;

    // Stage 3: masks plus the seed vector.
    logic                   p3_valid_reg;
    logic [SLOT_W-1:0]      p3_slot_reg;
    logic [PATTERN_LEN-1:0] star3_reg, match3_reg;
    logic [VEC_W-1:0]       end3_reg, seed3_reg;
    logic [VEC_W-1:0]       s2_ext, s2_t, seed;

    // Stage 4: matcher update.
    logic [VEC_W-1:0]  active_reg [NUM_PATTERNS];
    logic [VEC_W-1:0]  v0, adv, s3_ext, m3_ext, adv_t, newv;
    logic [USE_W-1:0]  n_use;
    logic              slot_used, hit_now;
    logic              hit_reg;
    logic [SLOT_W-1:0] first_reg;

    // Result register.
    logic                  m_valid_reg, m_valid_next;
    logic                  ign_reg;
    logic [OUT_SLOT_W-1:0] slot_out_reg;

    assign pipe_busy = p1_valid_reg || p2_valid_reg || p3_valid_reg;
    assign pop       = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer: one command at a time, one slot per cycle in a sweep.
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        char_next   = char_reg;
        cnt_next    = cnt_reg;
        prog_next   = prog_reg;
        out_load    = 1'b0;
        sweep_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty && head_cmd.op != OP_WRITE) begin
                    op_next     = head_cmd.op;
                    char_next   = head_cmd.char_code;
                    cnt_next    = '0;
                    sweep_start = 1'b1;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SLOT_W'(NUM_PATTERNS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    if (op_reg == OP_CHAR) begin
                        prog_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    prog_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_WRITE;
            char_reg  <= '0;
            cnt_reg   <= '0;
            prog_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            char_reg  <= char_next;
            cnt_reg   <= cnt_next;
            prog_reg  <= prog_next;
        end
    end

    // Pattern memory: byte write from the queue, registered row read per slot.
    always_ff @(posedge aclk) begin
        if (pop && head_cmd.op == OP_WRITE) begin
            pat_mem[head_cmd.slot][int'(head_cmd.pos) * CHAR_W +: CHAR_W] <=
                head_cmd.char_code;
        end
        if (state_reg == ST_SWEEP) begin
            row_reg <= pat_mem[cnt_reg];
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= (state_reg == ST_SWEEP);
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // Stage 2: classify every pattern position and find the terminator.
    // Bytes past the terminator may never have been written, so the masks
    // are built with a running flag that gates them off bit by bit.
    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < PATTERN_LEN; i++) begin
            zf[i]       = (row_reg[i*CHAR_W +: CHAR_W] == CH_END);
            is_star[i]  = (row_reg[i*CHAR_W +: CHAR_W] == CH_STAR);
            is_match[i] = (row_reg[i*CHAR_W +: CHAR_W] == CH_QMARK) ||
                          (row_reg[i*CHAR_W +: CHAR_W] == char_reg);
            // Positions below the first zero, and the first zero itself.
            below[i]    = !seen && !zf[i];
            lowest[i]   = !seen && zf[i];
            seen        = seen || zf[i];
        end
    end

    always_ff @(posedge aclk) begin
        p1_slot_reg <= cnt_reg;
        p2_slot_reg <= p1_slot_reg;
        star2_reg   <= is_star & below;
        match2_reg  <= is_match & below;
        end2_reg    <= {~|zf, lowest};
    end

    // Stage 3: seed is position 0 carried forward through leading stars.
    // The carry chain of star_mask + start_bits marks every position reached.
    always_comb begin
        s2_ext = {1'b0, star2_reg};
        s2_t   = {{PATTERN_LEN{1'b0}}, star2_reg[0]};
        seed   = ((s2_ext + s2_t) ^ s2_ext ^ s2_t) | VEC_W'(1);
    end

    always_ff @(posedge aclk) begin
        p3_slot_reg <= p2_slot_reg;
        star3_reg   <= star2_reg;
        match3_reg  <= match2_reg;
        end3_reg    <= end2_reg;
        seed3_reg   <= seed;
    end

    // Stage 4: advance the matcher by one character and close over stars.
    always_comb begin
        n_use     = (patterns_in_use > USE_W'(NUM_PATTERNS)) ?
                    USE_W'(NUM_PATTERNS) : patterns_in_use;
        v0        = prog_reg ? active_reg[p3_slot_reg] : seed3_reg;
        s3_ext    = {1'b0, star3_reg};
        m3_ext    = {1'b0, match3_reg};
        adv       = (v0 & s3_ext) | ((v0 & m3_ext) << 1);
        adv_t     = adv & s3_ext;
        newv      = adv | ((s3_ext + adv_t) ^ s3_ext ^ adv_t);
        slot_used = (USE_W'(p3_slot_reg) < n_use);
        hit_now   = (|(v0 & end3_reg)) && slot_used;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_PATTERNS; s++) begin
                active_reg[s] <= '0;
            end
        end else if (out_load) begin
            for (int s = 0; s < NUM_PATTERNS; s++) begin
                active_reg[s] <= '0;
            end
        end else if (p3_valid_reg && op_reg == OP_CHAR) begin
            active_reg[p3_slot_reg] <= newv;
        end
    end

    // Lowest matching slot: slots arrive in ascending order, keep the first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg   <= 1'b0;
            first_reg <= '0;
        end else if (sweep_start) begin
            hit_reg   <= 1'b0;
            first_reg <= '0;
        end else if (p3_valid_reg && op_reg == OP_END && hit_now && !hit_reg) begin
            hit_reg   <= 1'b1;
            first_reg <= p3_slot_reg;
        end
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            ign_reg      <= hit_reg;
            slot_out_reg <= OUT_SLOT_W'(first_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_ignored          = ign_reg;
    assign m_first_match_slot = slot_out_reg;

    `GPM_ASSERT_RST(a_result_only_end, aclk, aresetn, (state_reg == ST_RESULT) |-> (op_reg == OP_END))
    `GPM_ASSERT_RST(a_out_from_result, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == ST_RESULT))
    `GPM_ASSERT_RST(a_pipe_in_sweep, aclk, aresetn, p1_valid_reg |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
    `GPM_ASSERT_RST(a_end_unseeds, aclk, aresetn, $rose(m_valid_reg) |-> !prog_reg)
    `GPM_ASSERT_CLK(a_reset_clears_out, aclk, !aresetn |=> !m_valid_reg)

endmodule

`default_nettype wire

/* design/glob_pattern_set_matcher.sv */
// ---------------------------------------------------------------------------
// glob_pattern_set_matcher
// Matches streamed file names against a table of glob patterns.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    action, slot, position, char_code
//   m_       out        m_valid / m_ready    ignored, first_match_slot
//   apb      in         psel/penable/pready  patterns_in_use at address 0
//
// A pattern write is done in the engine as the queue hands it over. A name
// character or an end of name is taken from the queue, the single read port
// of the pattern memory then serves the slots one after another, and the
// 3-stage update pipe drains before the engine takes another command. An end
// of name then loads the result register.
// A two-entry command queue lets new transfers in while the engine works.
// Reset is synchronous and clears the matchers, the queue and the register;
// the pattern memory is not cleared. A stalled m_ready holds the end of the
// next name until the result register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module glob_pattern_set_matcher import gpm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input channel.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ACT_W-1:0]      s_action,
    input  wire logic [3:0]            s_slot,
    input  wire logic [POS_W-1:0]      s_position,
    input  wire logic [CHAR_W-1:0]     s_char_code,
    // Result channel.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_ignored,
    output logic [OUT_SLOT_W-1:0]      m_first_match_slot,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic REG_PATTERNS_IN_USE = 1'b0;

    logic [USE_W-1:0] piu_reg, piu_next;
    logic             cfg_wr;
    logic             q_full, q_empty;
    logic             push, pop;
    cmd_t             push_cmd, head_cmd;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        piu_next = piu_reg;
        if (cfg_wr && paddr[2] == REG_PATTERNS_IN_USE) begin
            piu_next = pwdata[USE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piu_reg <= '0;
        end else begin
            piu_reg <= piu_next;
        end
    end

    assign prdata = (paddr[2] == REG_PATTERNS_IN_USE) ? {{(32-USE_W){1'b0}}, piu_reg} : '0;

    // Front: take and classify transfers.
    gpm_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_slot      (s_slot),
        .s_position  (s_position),
        .s_char_code (s_char_code),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Command queue.
    gpm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    // Back: matching engine and result register.
    gpm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .patterns_in_use    (piu_reg),
        .q_empty            (q_empty),
        .head_cmd           (head_cmd),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ignored          (m_ignored),
        .m_first_match_slot (m_first_match_slot)
    );

endmodule

`default_nettype wire

/* bench/glob_verdict_pkg.sv */
// ---------------------------------------------------------------------------
// Glob verdict scoreboard
// Tracks the pattern table and the per-slot matcher vectors of the glob
// pattern set matcher, and keeps the verdicts owed for each end of name so
// that every result transfer can be compared in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package glob_verdict_pkg;
    import gpm_pkg::*;

    // One input transfer as the bench drives it.
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [3:0]        slot;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] char_code;
    } glob_item_t;

    // One verdict transfer of the result channel.
    typedef struct packed {
        logic                  ignored;
        logic [OUT_SLOT_W-1:0] slot;
    } verdict_t;

    typedef logic [CHAR_W-1:0] glyph_q_t[$];

    localparam int REPORT_LIMIT = 10;

    class match_verdict_board;
        logic [CHAR_W-1:0] glyphs  [NUM_PATTERNS][PATTERN_LEN];
        bit                written [NUM_PATTERNS][PATTERN_LEN];
        logic [VEC_W-1:0]  live    [NUM_PATTERNS];
        bit                name_open;
        logic [USE_W-1:0]  in_use;
        verdict_t          due[$];
        int                mismatches;

        function new();
            for (int s = 0; s < NUM_PATTERNS; s++) begin
                live[s] = '0;
                for (int i = 0; i < PATTERN_LEN; i++) begin
                    glyphs[s][i]  = CH_END;
                    written[s][i] = 1'b0;
                end
            end
            name_open  = 1'b0;
            in_use     = '0;
            mismatches = 0;
        endfunction

        function void set_in_use(logic [31:0] value);
            in_use = value[USE_W-1:0];
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Length of a pattern: up to its first terminator, or the full row.
        function int span(int s);
            for (int i = 0; i < PATTERN_LEN; i++) begin
                if (glyphs[s][i] == CH_END) return i;
            end
            return PATTERN_LEN;
        endfunction

        // True when, after the write, every entry up to the terminator has
        // been written, so the matcher never reads a stale entry.
        function bit keeps_terminated(int s, int p, logic [CHAR_W-1:0] c);
            logic [CHAR_W-1:0] g;
            bit                w;
            if (p >= PATTERN_LEN) return 1'b1;
            for (int i = 0; i < PATTERN_LEN; i++) begin
                g = (i == p) ? c : glyphs[s][i];
                w = (i == p) ? 1'b1 : written[s][i];
                if (!w) return 1'b0;
                if (g == CH_END) return 1'b1;
            end
            return 1'b1;
        endfunction

        // A star may match an empty run, so an active star activates the
        // next position as well; one ascending pass follows star chains.
        function logic [VEC_W-1:0] close_stars(int s, logic [VEC_W-1:0] v);
            int len;
            len = span(s);
            for (int i = 0; i < len; i++) begin
                if (v[i] && glyphs[s][i] == CH_STAR) v[i+1] = 1'b1;
            end
            return v;
        endfunction

        function logic [VEC_W-1:0] consume(int s, logic [VEC_W-1:0] v,
                                           logic [CHAR_W-1:0] c);
            int               len;
            logic [VEC_W-1:0] nv;
            len = span(s);
            nv  = '0;
            for (int i = 0; i < len; i++) begin
                if (v[i]) begin
                    if (glyphs[s][i] == CH_STAR) nv[i] = 1'b1;
                    else if (glyphs[s][i] == CH_QMARK || glyphs[s][i] == c) nv[i+1] = 1'b1;
                end
            end
            return close_stars(s, nv);
        endfunction

        // The first character or end of a name seeds every matcher.
        function void open_name();
            if (name_open) return;
            for (int s = 0; s < NUM_PATTERNS; s++)
                live[s] = close_stars(s, {{(VEC_W-1){1'b0}}, 1'b1});
            name_open = 1'b1;
        endfunction

        function void note_item(glob_item_t it);
            int       n;
            verdict_t v;
            case (it.action)
                ACT_PAT_WRITE: begin
                    if (it.position < PATTERN_LEN) begin
                        glyphs[it.slot][it.position]  = it.char_code;
                        written[it.slot][it.position] = 1'b1;
                    end
                end
                ACT_NAME_CHAR: begin
                    // A zero name byte is dropped.
                    if (it.char_code != CH_END) begin
                        open_name();
                        for (int s = 0; s < NUM_PATTERNS; s++)
                            live[s] = consume(s, live[s], it.char_code);
                    end
                end
                ACT_NAME_END: begin
                    n = (in_use > NUM_PATTERNS) ? NUM_PATTERNS : int'(in_use);
                    open_name();
                    v = '0;
                    for (int s = 0; s < n; s++) begin
                        if (live[s][span(s)]) begin
                            v.ignored = 1'b1;
                            v.slot    = OUT_SLOT_W'(s);
                            break;
                        end
                    end
                    due.push_back(v);
                    for (int s = 0; s < NUM_PATTERNS; s++) live[s] = '0;
                    name_open = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_verdict(logic ignored, logic [OUT_SLOT_W-1:0] slot);
            verdict_t want;
            if (due.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: unexpected verdict ignored=%0b first_match_slot=%0d",
                             $time, ignored, slot);
                mismatches++;
                return;
            end
            want = due.pop_front();
            if (ignored !== want.ignored || slot !== want.slot) begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: verdict mismatch ignored exp %0b got %0b, %s exp %0d got %0d",
                             $time, want.ignored, ignored, "first_match_slot",
                             want.slot, slot);
                mismatches++;
            end
        endfunction
    endclass

endpackage

/* bench/glob_pattern_set_matcher_tb.sv */
// ---------------------------------------------------------------------------
// glob_pattern_set_matcher_tb
// Loads glob patterns and streams file names through the matcher with random
// gaps on the input side and random stalls on the result side. Each verdict
// is compared in order against a scoreboard that tracks the pattern table
// and the matcher vectors, across several patterns_in_use settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module glob_pattern_set_matcher_tb;
    import gpm_pkg::*;
    import glob_verdict_pkg::*;

    localparam logic [ACT_W-1:0]  ACT_UNUSED          = 2'd3;
    localparam logic [2:0]        REG_PATTERNS_IN_USE = 3'd0;
    localparam logic [CHAR_W-1:0] CH_A                = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B                = 8'h62;
    localparam logic [CHAR_W-1:0] CH_C                = 8'h63;
    localparam logic [CHAR_W-1:0] CH_TOP              = 8'hFF;
    localparam int                SETTLE_CYCLES       = 100;
    localparam int                DRAIN_LIMIT         = 200000;

    logic                  aclk               = 1'b0;
    logic                  aresetn            = 1'b0;
    logic                  s_valid            = 1'b0;
    wire                   s_ready;
    logic [ACT_W-1:0]      s_action           = '0;
    logic [3:0]            s_slot             = '0;
    logic [POS_W-1:0]      s_position         = '0;
    logic [CHAR_W-1:0]     s_char_code        = '0;
    wire                   m_valid;
    logic                  m_ready            = 1'b0;
    wire                   m_ignored;
    wire [OUT_SLOT_W-1:0]  m_first_match_slot;
    logic                  psel               = 1'b0;
    logic                  penable            = 1'b0;
    logic                  pwrite             = 1'b0;
    logic [2:0]            paddr              = '0;
    logic [31:0]           pwdata             = '0;
    wire [31:0]            prdata;
    wire                   pready;

    match_verdict_board board = new();
    bit                 no_idle = 1'b0;
    int                 items_sent = 0;

    glob_pattern_set_matcher u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_slot             (s_slot),
        .s_position         (s_position),
        .s_char_code        (s_char_code),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ignored          (m_ignored),
        .m_first_match_slot (m_first_match_slot),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Drive one input transfer after a random gap and wait for it to be taken.
    task automatic send_item(input logic [ACT_W-1:0] action, input logic [3:0] slot,
                             input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] ch);
        glob_item_t it;
        int         gap;
        it.action    = action;
        it.slot      = slot;
        it.position  = pos;
        it.char_code = ch;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     = 1'b1;
        s_action    = action;
        s_slot      = slot;
        s_position  = pos;
        s_char_code = ch;
        do @(posedge aclk); while (!s_ready);
        board.note_item(it);
        items_sent++;
    endtask

    task automatic send_write(input int slot, input int pos, input logic [CHAR_W-1:0] ch);
        send_item(ACT_PAT_WRITE, 4'(slot), POS_W'(pos), ch);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send_item(ACT_NAME_CHAR, 4'($urandom_range(0, 15)), POS_W'($urandom_range(0, 63)), ch);
    endtask

    task automatic send_end();
        send_item(ACT_NAME_END, 4'($urandom_range(0, 15)), POS_W'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)));
    endtask

    // Hold the input side until every owed verdict has been taken.
    task automatic quiesce();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // Register write on the APB port, only once the block has gone idle.
    task automatic write_in_use(input logic [USE_W-1:0] value);
        logic [31:0] word;
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        word = $urandom();
        word[USE_W-1:0] = value;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_PATTERNS_IN_USE;
        pwdata  = word;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_in_use(word);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pattern_glyph();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return CH_A;
        if (r < 45) return CH_B;
        if (r < 65) return CH_STAR;
        if (r < 82) return CH_QMARK;
        if (r < 92) return CH_C;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] name_glyph();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return CH_A;
        if (r < 72) return CH_B;
        if (r < 84) return CH_C;
        if (r < 90) return CH_STAR;
        if (r < 95) return CH_QMARK;
        return 8'($urandom_range(1, 255));
    endfunction

    // Terminator first, then the characters from the end backward, so the
    // slot stays a fully written pattern after every single transfer.
    task automatic load_pattern(input int slot, input glyph_q_t q);
        if (q.size() < PATTERN_LEN) send_write(slot, q.size(), CH_END);
        for (int i = q.size() - 1; i >= 0; i--) send_write(slot, i, q[i]);
    endtask

    task automatic random_pattern(input int slot);
        glyph_q_t q;
        int       len;
        len = $urandom_range(0, 6);
        repeat (len) q.push_back(pattern_glyph());
        load_pattern(slot, q);
    endtask

    // A full-row pattern with no terminator.
    task automatic long_pattern(input int slot);
        glyph_q_t q;
        int       r;
        for (int i = 0; i < PATTERN_LEN; i++) begin
            r = $urandom_range(0, 9);
            q.push_back(r < 5 ? CH_STAR : r < 7 ? CH_QMARK : r < 9 ? CH_A : CH_TOP);
        end
        q[PATTERN_LEN-1] = CH_TOP;
        load_pattern(slot, q);
    endtask

    // Build a name that a slot's pattern is likely to match, sometimes spoiled.
    function automatic glyph_q_t render_name(input int slot);
        glyph_q_t         q;
        logic [CHAR_W-1:0] g;
        for (int i = 0; i < board.span(slot); i++) begin
            g = board.glyphs[slot][i];
            if (g == CH_STAR) repeat ($urandom_range(0, 2)) q.push_back(name_glyph());
            else if (g == CH_QMARK) q.push_back(name_glyph());
            else q.push_back(g);
        end
        if ($urandom_range(0, 3) == 0) begin
            if (q.size() > 0) q[$urandom_range(0, q.size() - 1)] = name_glyph();
            else q.push_back(name_glyph());
        end
        return q;
    endfunction

    function automatic glyph_q_t random_name();
        glyph_q_t q;
        repeat ($urandom_range(0, 6)) q.push_back(name_glyph());
        return q;
    endfunction

    // A pattern write that keeps the target slot terminated.
    task automatic patch_pattern(input int pos_max);
        int                s;
        int                p;
        logic [CHAR_W-1:0] c;
        s = $urandom_range(0, 15);
        p = (pos_max < 0) ? $urandom_range(0, board.span(s)) : $urandom_range(0, pos_max);
        c = (pos_max < 0) ? pattern_glyph() : 8'($urandom_range(0, 255));
        if (!board.keeps_terminated(s, p, c)) c = CH_END;
        send_write(s, p, c);
    endtask

    // Stream a name, with occasional zero bytes and a pattern write mid-name.
    task automatic send_name(input glyph_q_t q);
        int cut;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, q.size()) : -1;
        for (int i = 0; i <= q.size(); i++) begin
            if (i == cut) patch_pattern(-1);
            if (i < q.size()) begin
                if ($urandom_range(0, 19) == 0) send_char(CH_END);
                send_char(q[i]);
            end
        end
        send_end();
    endtask

    // A single transfer with any action and any field values.
    task automatic noise_item();
        logic [ACT_W-1:0] action;
        action = ACT_W'($urandom_range(0, 3));
        if (action == ACT_PAT_WRITE) patch_pattern(63);
        else send_item(action, 4'($urandom_range(0, 15)), POS_W'($urandom_range(0, 63)),
                       8'($urandom_range(0, 255)));
    endtask

    task automatic random_chunk();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) random_pattern($urandom_range(0, 15));
        else if (r < 55) send_name(render_name($urandom_range(0, 15)));
        else if (r < 80) send_name(random_name());
        else noise_item();
    endtask

    // Result side: random stall before each transfer, then compare it.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_verdict(m_ignored, m_first_match_slot);
        end
    end

    // Stimulus and end of run.
    initial begin
        glyph_q_t q;
        int       plan [10];
        int       target;
        bit       paused;
        int       waited;
        plan = '{16, 0, 1, 31, 17, 16, 9, 16, 2, 12};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_in_use(USE_W'(NUM_PATTERNS));
        // Every slot starts as an empty pattern so no stale entry is ever read.
        for (int s = 0; s < NUM_PATTERNS; s++) send_write(s, 0, CH_END);

        // Directed part: empty name, wildcards, literal star, extremes.
        send_end();
        q = '{CH_A, CH_STAR};
        load_pattern(0, q);
        q = '{CH_QMARK};
        load_pattern(1, q);
        q = '{CH_STAR, CH_QMARK};
        load_pattern(15, q);
        send_char(CH_A);
        send_char(CH_END);
        send_end();
        send_char(CH_STAR);
        send_end();
        send_char(CH_TOP);
        send_end();
        send_write(15, PATTERN_LEN, CH_A);
        send_item(ACT_UNUSED, 4'hF, 6'h3F, CH_TOP);
        send_char(CH_A);
        send_write(1, 0, CH_STAR);
        send_char(CH_B);
        send_end();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 10; p++) begin
            write_in_use(USE_W'(p == 7 ? $urandom_range(0, 31) : plan[p]));
            no_idle = (p % 4 == 1);
            if (p == 2) long_pattern(7);
            if (p == 6) long_pattern(15);
            target = items_sent + 135;
            paused = 1'b0;
            while (items_sent < target) begin
                if (p == 4 && !paused && items_sent > target - 75) begin
                    quiesce();
                    paused = 1'b1;
                end
                random_chunk();
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        waited  = 0;
        while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("glob_pattern_set_matcher regression: pass");
        end else begin
            if (board.pending() != 0)
                $display("%0d verdicts never arrived", board.pending());
            $display("glob_pattern_set_matcher regression: fail");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("timeout with %0d verdicts outstanding", board.pending());
        $display("glob_pattern_set_matcher regression: fail");
        $finish;
    end

endmodule
